// ===== rtl/arenc_pkg.sv =====
// Package for the arithmetic encoder: sizes, codes, command and status types.
// Used by every module of the encoder; depends on nothing.
`timescale 1ns / 1ps

package arenc_pkg;

  localparam int SYMBOLS     = 256;
  localparam int PRECISION   = 32;
  localparam int COUNT_BITS  = 16;
  localparam int PENDING_MAX = 255;
  localparam int MAX_BYTES   = 63;

  localparam int SYM_W     = 9;
  localparam int PEND_W    = 8;
  localparam int RANGE_W   = PRECISION + 1;
  localparam int PROD_W    = RANGE_W + COUNT_BITS;
  localparam int DIV_STEPS = (PROD_W + 1) / 2;
  localparam int NUM_W     = 2 * DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int GUARD_W   = $clog2(PRECISION + 2);
  localparam int OCNT_W    = $clog2(MAX_BYTES + 1);
  localparam int EMIT_W    = PEND_W + 1;

  localparam logic [PRECISION-1:0] HALF    = PRECISION'(1) << (PRECISION - 1);
  localparam logic [PRECISION-1:0] QUARTER = PRECISION'(1) << (PRECISION - 2);
  localparam logic [SYM_W-1:0]     TOT_ADDR = SYM_W'(SYMBOLS);
  localparam logic [PEND_W-1:0]    PEND_SAT = PEND_W'(PENDING_MAX);

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_WRITE, OP_RANGE, OP_MUL, OP_DIV, OP_SAVEQ, OP_UPDATE,
    OP_RESC, OP_PUT, OP_PAD, OP_FINPEND, OP_FINRST, OP_FLUSH, OP_STAT
  } dp_op_e;

  typedef enum logic [1:0] {RD_SYM, RD_SYM1, RD_TOT} rd_sel_e;

  typedef enum logic [1:0] {CAP_NONE, CAP_LO, CAP_HI, CAP_TOT} cap_e;

  typedef struct packed {
    dp_op_e     op;
    rd_sel_e    rd_sel;
    cap_e       cap;
    logic       sel_hi;
    logic       last;
    logic [1:0] stat;
  } cmd_t;

  typedef struct packed {
    logic sym_big;
    logic bad;
    logic div_done;
    logic resc_emit;
    logic resc_mid;
    logic guard_done;
    logic emit_done;
    logic bits_zero;
    logic out_free;
    logic hold_v;
    logic ovf;
  } sts_t;

endpackage

// ===== rtl/arenc_datapath.sv =====
// Encoder datapath: count table, interval registers, multiplier, radix-4 divider,
// bit packer and output register. Depends on arenc_pkg.
`timescale 1ns / 1ps

module arenc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  arenc_pkg::cmd_t                  cmd_i,
  output arenc_pkg::sts_t                  sts_o,
  input  logic [arenc_pkg::SYM_W-1:0]      symbol_i,
  input  logic [arenc_pkg::COUNT_BITS-1:0] cum_value_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [7:0]                       out_byte_o,
  output logic                             last_o,
  output logic [1:0]                       status_o
);

  logic [arenc_pkg::COUNT_BITS-1:0] cum_mem [0:arenc_pkg::SYMBOLS];
  logic [arenc_pkg::COUNT_BITS-1:0] rd_q;
  logic [arenc_pkg::SYM_W-1:0]      sym_q;
  logic [arenc_pkg::COUNT_BITS-1:0] val_q, lo_c_q, hi_c_q, tot_q;
  logic [arenc_pkg::SYM_W-1:0]      rd_addr;

  logic [arenc_pkg::RANGE_W-1:0]    range_q, qhi_q;
  logic [arenc_pkg::NUM_W-1:0]      num_q;
  logic [arenc_pkg::COUNT_BITS-1:0] rem_q;
  logic [arenc_pkg::DIV_CNT_W-1:0]  div_cnt_q;

  logic [arenc_pkg::PRECISION-1:0]  low_q, high_q;
  logic [arenc_pkg::PEND_W-1:0]     pending_q;
  logic [7:0]                       shift_q, hold_q;
  logic [2:0]                       bits_q;
  logic                             hold_v_q, ovf_q;
  logic [arenc_pkg::OCNT_W-1:0]     ocnt_q;
  logic [arenc_pkg::GUARD_W-1:0]    guard_q;
  logic [arenc_pkg::EMIT_W-1:0]     emit_left_q;
  logic                             nbit_q, inv_q;

  logic                             out_valid_q, last_q;
  logic [7:0]                       byte_q;
  logic [1:0]                       stat_q;

  // read address and table
  always_comb begin
    unique case (cmd_i.rd_sel)
      arenc_pkg::RD_SYM:  rd_addr = sym_q;
      arenc_pkg::RD_SYM1: rd_addr = sym_q + arenc_pkg::SYM_W'(1);
      default:            rd_addr = arenc_pkg::TOT_ADDR;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == arenc_pkg::OP_WRITE && sym_q <= arenc_pkg::TOT_ADDR) begin
      cum_mem[sym_q] <= val_q;
    end
    rd_q <= cum_mem[rd_addr];
  end

  // multiply and divide
  logic [arenc_pkg::COUNT_BITS-1:0] mul_c;
  logic [arenc_pkg::PROD_W-1:0]     prod;
  logic [arenc_pkg::COUNT_BITS:0]   t1, t2, totx;
  logic                             ge1, ge2;
  logic [arenc_pkg::COUNT_BITS-1:0] r1, r2;

  assign mul_c = cmd_i.sel_hi ? hi_c_q : lo_c_q;
  assign prod  = range_q * mul_c;
  assign totx  = {1'b0, tot_q};
  assign t1    = {rem_q, num_q[arenc_pkg::NUM_W-1]};
  assign ge1   = t1 >= totx;
  assign r1    = ge1 ? arenc_pkg::COUNT_BITS'(t1 - totx) : t1[arenc_pkg::COUNT_BITS-1:0];
  assign t2    = {r1, num_q[arenc_pkg::NUM_W-2]};
  assign ge2   = t2 >= totx;
  assign r2    = ge2 ? arenc_pkg::COUNT_BITS'(t2 - totx) : t2[arenc_pkg::COUNT_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == arenc_pkg::OP_LATCH) begin
      sym_q <= symbol_i;
      val_q <= cum_value_i;
    end
    unique case (cmd_i.cap)
      arenc_pkg::CAP_LO:  lo_c_q <= rd_q;
      arenc_pkg::CAP_HI:  hi_c_q <= rd_q;
      arenc_pkg::CAP_TOT: tot_q  <= rd_q;
      default: ;
    endcase
    if (cmd_i.op == arenc_pkg::OP_RANGE) begin
      range_q <= {1'b0, high_q} - {1'b0, low_q} + arenc_pkg::RANGE_W'(1);
    end
    if (cmd_i.op == arenc_pkg::OP_MUL) begin
      num_q <= arenc_pkg::NUM_W'(prod);
      rem_q <= '0;
    end else if (cmd_i.op == arenc_pkg::OP_DIV) begin
      num_q <= {num_q[arenc_pkg::NUM_W-3:0], ge1, ge2};
      rem_q <= r2;
    end
    if (cmd_i.op == arenc_pkg::OP_SAVEQ) begin
      qhi_q <= num_q[arenc_pkg::RANGE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.op == arenc_pkg::OP_MUL) begin
      div_cnt_q <= '0;
    end else if (cmd_i.op == arenc_pkg::OP_DIV) begin
      div_cnt_q <= div_cnt_q + arenc_pkg::DIV_CNT_W'(1);
    end
  end

  // rescale decisions
  logic                            c_low, c_high, c_mid;
  logic [arenc_pkg::PRECISION-1:0] adj_low, adj_high;
  logic [arenc_pkg::PEND_W-1:0]    pend_inc;
  logic                            pend_sat;

  assign c_low    = high_q < arenc_pkg::HALF;
  assign c_high   = low_q >= arenc_pkg::HALF;
  assign c_mid    = low_q >= arenc_pkg::QUARTER &&
                    high_q < (arenc_pkg::HALF + arenc_pkg::QUARTER);
  assign pend_sat = pending_q == arenc_pkg::PEND_SAT;
  assign pend_inc = pend_sat ? pending_q : pending_q + arenc_pkg::PEND_W'(1);

  always_comb begin
    adj_low  = low_q;
    adj_high = high_q;
    if (c_low) begin
      adj_low  = low_q;
    end else if (c_high) begin
      adj_low  = low_q - arenc_pkg::HALF;
      adj_high = high_q - arenc_pkg::HALF;
    end else begin
      adj_low  = low_q - arenc_pkg::QUARTER;
      adj_high = high_q - arenc_pkg::QUARTER;
    end
  end

  // bit packer
  logic       put_req, put_bit, complete, room, stall, put_en, out_free;
  logic [7:0] nshift;
  logic       flush_en, stat_en, hold_move;

  assign out_free  = !out_valid_q || out_ready_i;
  assign put_req   = cmd_i.op == arenc_pkg::OP_PUT || cmd_i.op == arenc_pkg::OP_PAD;
  assign put_bit   = (cmd_i.op == arenc_pkg::OP_PUT) ? nbit_q : 1'b0;
  assign nshift    = {shift_q[6:0], put_bit};
  assign complete  = bits_q == 3'd7;
  assign room      = ocnt_q != arenc_pkg::OCNT_W'(arenc_pkg::MAX_BYTES);
  assign stall     = complete && room && hold_v_q && !out_free;
  assign put_en    = put_req && !stall;
  assign hold_move = put_en && complete && room && hold_v_q;
  assign flush_en  = cmd_i.op == arenc_pkg::OP_FLUSH && out_free;
  assign stat_en   = cmd_i.op == arenc_pkg::OP_STAT && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= '0;
      high_q      <= '1;
      pending_q   <= '0;
      shift_q     <= '0;
      bits_q      <= '0;
      hold_v_q    <= 1'b0;
      ovf_q       <= 1'b0;
      ocnt_q      <= '0;
      guard_q     <= '0;
      emit_left_q <= '0;
      nbit_q      <= 1'b0;
      inv_q       <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        arenc_pkg::OP_LATCH: begin
          ocnt_q <= '0;
          ovf_q  <= 1'b0;
        end
        arenc_pkg::OP_UPDATE: begin
          high_q  <= arenc_pkg::PRECISION'(low_q + qhi_q - arenc_pkg::RANGE_W'(1));
          low_q   <= arenc_pkg::PRECISION'(low_q + num_q[arenc_pkg::RANGE_W-1:0]);
          guard_q <= '0;
        end
        arenc_pkg::OP_RESC: begin
          low_q   <= {adj_low[arenc_pkg::PRECISION-2:0], 1'b0};
          high_q  <= {adj_high[arenc_pkg::PRECISION-2:0], 1'b1};
          guard_q <= guard_q + arenc_pkg::GUARD_W'(1);
          if (c_low || c_high) begin
            emit_left_q <= {1'b0, pending_q} + arenc_pkg::EMIT_W'(1);
            nbit_q      <= c_high;
            inv_q       <= !c_high;
            pending_q   <= '0;
          end else begin
            pending_q <= pend_inc;
            if (pend_sat) ovf_q <= 1'b1;
          end
        end
        arenc_pkg::OP_FINPEND: begin
          emit_left_q <= {1'b0, pend_inc} + arenc_pkg::EMIT_W'(1);
          nbit_q      <= low_q >= arenc_pkg::QUARTER;
          inv_q       <= low_q < arenc_pkg::QUARTER;
          pending_q   <= '0;
          if (pend_sat) ovf_q <= 1'b1;
        end
        arenc_pkg::OP_FINRST: begin
          low_q     <= '0;
          high_q    <= '1;
          pending_q <= '0;
          shift_q   <= '0;
          bits_q    <= '0;
        end
        default: ;
      endcase
      if (put_en) begin
        shift_q <= nshift;
        bits_q  <= bits_q + 3'd1;
        if (cmd_i.op == arenc_pkg::OP_PUT) begin
          emit_left_q <= emit_left_q - arenc_pkg::EMIT_W'(1);
          nbit_q      <= inv_q;
        end
        if (complete && room) begin
          hold_v_q <= 1'b1;
          ocnt_q   <= ocnt_q + arenc_pkg::OCNT_W'(1);
        end
      end
      if (flush_en) hold_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (put_en && complete && room) hold_q <= nshift;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (hold_move || flush_en || stat_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_move) begin
      byte_q <= hold_q;
      last_q <= 1'b0;
      stat_q <= arenc_pkg::STAT_OK;
    end else if (flush_en) begin
      byte_q <= hold_q;
      last_q <= cmd_i.last;
      stat_q <= arenc_pkg::STAT_OK;
    end else if (stat_en) begin
      byte_q <= '0;
      last_q <= 1'b1;
      stat_q <= cmd_i.stat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;
  assign status_o    = stat_q;

  always_comb begin
    sts_o.sym_big    = sym_q >= arenc_pkg::TOT_ADDR;
    sts_o.bad        = tot_q == '0 || hi_c_q <= lo_c_q || hi_c_q > tot_q;
    sts_o.div_done   = div_cnt_q == arenc_pkg::DIV_CNT_W'(arenc_pkg::DIV_STEPS);
    sts_o.resc_emit  = c_low || c_high;
    sts_o.resc_mid   = c_mid;
    sts_o.guard_done = guard_q == arenc_pkg::GUARD_W'(arenc_pkg::PRECISION + 1);
    sts_o.emit_done  = emit_left_q == '0;
    sts_o.bits_zero  = bits_q == 3'd0;
    sts_o.out_free   = out_free;
    sts_o.hold_v     = hold_v_q;
    sts_o.ovf        = ovf_q;
  end

endmodule

// ===== rtl/arenc_ctrl.sv =====
// Encoder controller: sequences table access, interval narrowing, rescaling,
// bit emission and result delivery. Depends on arenc_pkg.
`timescale 1ns / 1ps

module arenc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      kind_i,
  input  arenc_pkg::sts_t sts_i,
  output arenc_pkg::cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_LOAD   = 5'd1;
  localparam logic [4:0] S_ENC    = 5'd2;
  localparam logic [4:0] S_RDHI   = 5'd3;
  localparam logic [4:0] S_RDTOT  = 5'd4;
  localparam logic [4:0] S_CAPTOT = 5'd5;
  localparam logic [4:0] S_CHECK  = 5'd6;
  localparam logic [4:0] S_MULHI  = 5'd7;
  localparam logic [4:0] S_DIVHI  = 5'd8;
  localparam logic [4:0] S_MULLO  = 5'd9;
  localparam logic [4:0] S_DIVLO  = 5'd10;
  localparam logic [4:0] S_RESC   = 5'd11;
  localparam logic [4:0] S_EMIT   = 5'd12;
  localparam logic [4:0] S_FIN    = 5'd13;
  localparam logic [4:0] S_FEMIT  = 5'd14;
  localparam logic [4:0] S_PAD    = 5'd15;
  localparam logic [4:0] S_END    = 5'd16;
  localparam logic [4:0] S_STAT   = 5'd17;
  localparam logic [4:0] S_BAD    = 5'd18;

  logic [4:0] state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.op      = arenc_pkg::OP_NONE;
    cmd_o.rd_sel  = arenc_pkg::RD_SYM;
    cmd_o.cap     = arenc_pkg::CAP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = arenc_pkg::OP_LATCH;
          unique case (kind_i)
            arenc_pkg::KIND_LOAD:   state_d = S_LOAD;
            arenc_pkg::KIND_ENCODE: state_d = S_ENC;
            arenc_pkg::KIND_FINISH: state_d = S_FIN;
            default:                state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.op = arenc_pkg::OP_WRITE;
        state_d  = S_IDLE;
      end
      S_ENC: begin
        cmd_o.rd_sel = arenc_pkg::RD_SYM;
        state_d      = sts_i.sym_big ? S_BAD : S_RDHI;
      end
      S_RDHI: begin
        cmd_o.rd_sel = arenc_pkg::RD_SYM1;
        cmd_o.cap    = arenc_pkg::CAP_LO;
        state_d      = S_RDTOT;
      end
      S_RDTOT: begin
        cmd_o.rd_sel = arenc_pkg::RD_TOT;
        cmd_o.cap    = arenc_pkg::CAP_HI;
        state_d      = S_CAPTOT;
      end
      S_CAPTOT: begin
        cmd_o.cap = arenc_pkg::CAP_TOT;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.bad) begin
          state_d = S_BAD;
        end else begin
          cmd_o.op = arenc_pkg::OP_RANGE;
          state_d  = S_MULHI;
        end
      end
      S_MULHI: begin
        cmd_o.op     = arenc_pkg::OP_MUL;
        cmd_o.sel_hi = 1'b1;
        state_d      = S_DIVHI;
      end
      S_DIVHI: begin
        if (sts_i.div_done) begin
          cmd_o.op = arenc_pkg::OP_SAVEQ;
          state_d  = S_MULLO;
        end else begin
          cmd_o.op = arenc_pkg::OP_DIV;
        end
      end
      S_MULLO: begin
        cmd_o.op = arenc_pkg::OP_MUL;
        state_d  = S_DIVLO;
      end
      S_DIVLO: begin
        if (sts_i.div_done) begin
          cmd_o.op = arenc_pkg::OP_UPDATE;
          state_d  = S_RESC;
        end else begin
          cmd_o.op = arenc_pkg::OP_DIV;
        end
      end
      S_RESC: begin
        if (sts_i.guard_done || !(sts_i.resc_emit || sts_i.resc_mid)) begin
          state_d = S_END;
        end else begin
          cmd_o.op = arenc_pkg::OP_RESC;
          if (sts_i.resc_emit) state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.emit_done) state_d = S_RESC;
        else cmd_o.op = arenc_pkg::OP_PUT;
      end
      S_FIN: begin
        cmd_o.op = arenc_pkg::OP_FINPEND;
        state_d  = S_FEMIT;
      end
      S_FEMIT: begin
        if (sts_i.emit_done) state_d = S_PAD;
        else cmd_o.op = arenc_pkg::OP_PUT;
      end
      S_PAD: begin
        if (sts_i.bits_zero) begin
          cmd_o.op = arenc_pkg::OP_FINRST;
          state_d  = S_END;
        end else begin
          cmd_o.op = arenc_pkg::OP_PAD;
        end
      end
      S_END: begin
        if (sts_i.hold_v) begin
          if (sts_i.out_free) begin
            cmd_o.op   = arenc_pkg::OP_FLUSH;
            cmd_o.last = !sts_i.ovf;
            state_d    = sts_i.ovf ? S_STAT : S_IDLE;
          end
        end else begin
          state_d = sts_i.ovf ? S_STAT : S_IDLE;
        end
      end
      S_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.op   = arenc_pkg::OP_STAT;
          cmd_o.stat = arenc_pkg::STAT_OVF;
          state_d    = S_IDLE;
        end
      end
      S_BAD: begin
        if (sts_i.out_free) begin
          cmd_o.op   = arenc_pkg::OP_STAT;
          cmd_o.stat = arenc_pkg::STAT_ZERO;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/arithmetic_encoder_unit.sv =====
// Arithmetic encoder top level: controller plus datapath.
// An encode reads the count table, runs two radix-4 divisions, then the rescale steps and the
// bits they emit; a finish emits the pending bits and pads the last byte. One transaction is
// handled at a time, and output stalls hold the encoder up.
// Reset: asynchronous, active low; clears the interval, pending count and packer. The count
// table is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module arithmetic_encoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       kind_i,
  input  logic [arenc_pkg::SYM_W-1:0]      symbol_i,
  input  logic [arenc_pkg::COUNT_BITS-1:0] cum_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       out_byte_o,
  output logic                             last_o,
  output logic [1:0]                       status_o
);

  arenc_pkg::cmd_t cmd;
  arenc_pkg::sts_t sts;

  arenc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arenc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .symbol_i    (symbol_i),
    .cum_value_i (cum_value_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

endmodule

// ===== rtl/arenc_checker.sv =====
// Port-level checks for the arithmetic encoder, bound to the top level.
// Depends on arenc_pkg and arithmetic_encoder_unit.
`timescale 1ns / 1ps

module arenc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_o,
  input logic [1:0] status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(last_o) && $stable(status_o))
    else $error("output changed while stalled");

  a_stat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != arenc_pkg::STAT_OK |-> last_o)
    else $error("status result not last");

  a_stat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != arenc_pkg::STAT_OK |-> out_byte_o == 8'd0)
    else $error("status result carries data");

  a_stat_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == arenc_pkg::STAT_OK || status_o == arenc_pkg::STAT_ZERO ||
    status_o == arenc_pkg::STAT_OVF)
    else $error("bad status code");

endmodule

bind arithmetic_encoder_unit arenc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o),
  .status_o    (status_o)
);
